/* rtl/uscx_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the URL scheme extractor.
// Depends on nothing; imported by every module of the block.
package uscx_pkg;

   // Position counter width and the width of reported positions
   localparam int POSITION_BITS = 16;
   localparam int OUT_BITS      = 16;

   // Lower-cased history window and restart counter
   localparam int WINDOW_LEN  = 7;
   localparam int COUNT_BITS  = 4;
   localparam logic [COUNT_BITS-1:0] RESTART_SAT = COUNT_BITS'(8);

   // Distance from the current byte back to a scheme's first character
   localparam int SPAN_HTTP  = 6;
   localparam int SPAN_FTP   = 5;
   localparam int SPAN_HTTPS = 7;

   // Result queue between the scanner and the result port
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

   // Character codes
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   typedef logic [7:0]               byte_type;
   typedef logic [POSITION_BITS-1:0] pos_type;
   typedef logic [OUT_BITS-1:0]      out_pos_type;
   typedef logic [COUNT_BITS-1:0]    count_type;

   // One reported URL as it travels through the queue
   typedef struct packed {
      out_pos_type url_start;
      out_pos_type url_end;
      logic        ended_at_text_end;
      logic        position_wrapped;
   } result_type;

   // Low bits of a position as reported on the result port
   function automatic out_pos_type pos_out(input pos_type p);
      logic [31:0] wide;
      wide = 32'(p);
      return wide[OUT_BITS-1:0];
   endfunction

   // Fold ASCII A..Z to lower case
   function automatic byte_type fold_case(input byte_type c);
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         return c + CASE_OFFSET;
      end
      return c;
   endfunction

endpackage

/* rtl/uscx_front.sv */
`timescale 1ns / 1ps
// Scanner front end: keeps the byte window and position state, detects schemes
// and terminators, and emits one result record per closed URL. Uses uscx_pkg.
module uscx_front
   import uscx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  byte_type   item_byte,
   input  logic       item_last,
   output logic       ev_valid,
   output result_type ev_data
);

   byte_type  window_ff [WINDOW_LEN];
   count_type count_ff;
   logic      inside_ff;
   pos_type   start_ff;
   pos_type   pos_ff;
   logic      wrap_ff;

   count_type count_in;
   logic      inside_in;
   pos_type   start_in;
   pos_type   pos_in;
   logic      wrap_in;

   byte_type  lc;
   pos_type   next_pos;
   logic      wraps_now;
   logic      is_term;
   logic      term_hit;
   logic      sep_hit;
   count_type avail;
   logic      fit_http, fit_ftp, fit_https;
   logic      match;
   pos_type   match_start;
   logic      restart;
   logic      open_after;

   // Byte classification and position arithmetic
   always_comb begin
      lc        = fold_case(item_byte);
      next_pos  = pos_ff + pos_type'(1);
      wraps_now = (next_pos == '0);
      is_term   = item_byte inside {CH_QUOTE, CH_LT, CH_GT, CH_SPACE,
                                    CH_TAB, CH_APOS, CH_CR, CH_LF};
      term_hit  = inside_ff && is_term;
      sep_hit   = !inside_ff && item_byte == CH_SLASH && window_ff[0] == CH_SLASH &&
                  window_ff[1] == CH_COLON && count_ff >= count_type'(2);
      avail     = count_ff - count_type'(2);
   end

   // Scheme comparison over the window, newest byte first
   always_comb begin
      fit_http  = avail >= count_type'(4) &&
                  window_ff[2] == "p" && window_ff[3] == "t" &&
                  window_ff[4] == "t" && window_ff[5] == "h";
      fit_ftp   = avail >= count_type'(3) &&
                  window_ff[2] == "p" && window_ff[3] == "t" &&
                  window_ff[4] == "f";
      fit_https = avail >= count_type'(5) &&
                  window_ff[2] == "s" && window_ff[3] == "p" &&
                  window_ff[4] == "t" && window_ff[5] == "t" &&
                  window_ff[6] == "h";
      match     = sep_hit && (fit_http || fit_ftp || fit_https);
      // http wins over ftp, ftp over https
      if (fit_http) begin
         match_start = pos_ff - pos_type'(SPAN_HTTP);
      end else if (fit_ftp) begin
         match_start = pos_ff - pos_type'(SPAN_FTP);
      end else begin
         match_start = pos_ff - pos_type'(SPAN_HTTPS);
      end
   end

   // Result record and next state
   always_comb begin
      restart    = term_hit || sep_hit;
      open_after = inside_ff ? !term_hit : match;

      ev_valid = 1'b0;
      ev_data  = '0;
      if (item_valid && term_hit) begin
         ev_valid                  = 1'b1;
         ev_data.url_start         = pos_out(start_ff);
         ev_data.url_end           = pos_out(pos_ff);
         ev_data.ended_at_text_end = 1'b0;
         ev_data.position_wrapped  = wrap_ff;
      end else if (item_valid && item_last && open_after) begin
         ev_valid                  = 1'b1;
         ev_data.url_start         = pos_out(inside_ff ? start_ff : match_start);
         ev_data.url_end           = pos_out(next_pos);
         ev_data.ended_at_text_end = 1'b1;
         ev_data.position_wrapped  = wrap_ff || wraps_now;
      end

      if (restart) begin
         count_in = '0;
      end else if (count_ff < RESTART_SAT) begin
         count_in = count_ff + count_type'(1);
      end else begin
         count_in = count_ff;
      end
      inside_in = open_after;
      start_in  = match ? match_start : start_ff;
      pos_in    = next_pos;
      wrap_in   = wrap_ff || wraps_now;
   end

   // State registers; the final byte of a text clears everything
   always_ff @(posedge clock) begin
      if (reset || (item_valid && item_last)) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         count_ff  <= '0;
         inside_ff <= 1'b0;
         start_ff  <= '0;
         pos_ff    <= '0;
         wrap_ff   <= 1'b0;
      end else if (item_valid) begin
         for (int i = WINDOW_LEN - 1; i > 0; i--) begin
            window_ff[i] <= window_ff[i-1];
         end
         window_ff[0] <= lc;
         count_ff     <= count_in;
         inside_ff    <= inside_in;
         start_ff     <= start_in;
         pos_ff       <= pos_in;
         wrap_ff      <= wrap_in;
      end
   end

`ifndef SYNTHESIS
   a_ev_needs_item: assert property (@(posedge clock) disable iff (reset)
      ev_valid |-> item_valid)
      else $error("result emitted without an accepted byte");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      item_valid && item_last |=> pos_ff == '0 && !inside_ff && count_ff == '0)
      else $error("state not cleared after final byte");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RESTART_SAT)
      else $error("restart counter beyond saturation");
   a_term_from_open: assert property (@(posedge clock) disable iff (reset)
      ev_valid && !ev_data.ended_at_text_end |-> inside_ff)
      else $error("terminator result without an open URL");
`endif

endmodule

/* rtl/uscx_fifo.sv */
`timescale 1ns / 1ps
// Result queue and back end: holds closed URLs until the result port takes
// them, presenting the oldest at the head. Uses uscx_pkg.
module uscx_fifo
   import uscx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  result_type wr_data,
   input  logic       rd_en,
   output result_type rd_data,
   output logic       is_full,
   output logic       is_empty
);

   result_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0]  count_ff;
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_in, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0]  count_in;
   logic                      do_wr, do_rd;

   // Status and head of queue
   always_comb begin
      is_full  = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
      is_empty = (count_ff == '0);
      do_wr    = wr_en && !is_full;
      do_rd    = rd_en && !is_empty;
      rd_data  = entry_ff[rd_ptr_ff];
   end

   // Pointer and occupancy update, wrapping at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                   : wr_ptr_ff + FIFO_PTR_BITS'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                   : rd_ptr_ff + FIFO_PTR_BITS'(1);
      end
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + FIFO_CNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - FIFO_CNT_BITS'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("queue occupancy beyond depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      is_full |-> !do_wr)
      else $error("write into a full queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      is_empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with pointers apart");
`endif

endmodule

/* rtl/url_scheme_extractor_unit.sv */
`timescale 1ns / 1ps
// Top level of the URL scheme extractor: scanner front end feeding a result
// queue. Depends on uscx_pkg, uscx_front and uscx_fifo.
//
//   channel   handshake        payload
//   --------  ---------------  ----------------------------------------------
//   request   push / full      req_text_byte, req_last_byte
//   result    empty / pop      rsp_url_start, rsp_url_end,
//                              rsp_ended_at_text_end, rsp_position_wrapped
//
// One request is taken per cycle while full is low; the scanner state updates in the same cycle.
// A result enters the queue when its request is taken and shows on the rsp_ ports once it is at the head.
// The four-entry result queue sets how long the result side may stall before
// full rises; pop and push may both fire in one cycle.
// Synchronous reset clears the scanner state and empties the queue.
module url_scheme_extractor_unit
   import uscx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_text_byte,
   input  logic        req_last_byte,
   input  logic        push,
   output logic        full,
   output logic [15:0] rsp_url_start,
   output logic [15:0] rsp_url_end,
   output logic        rsp_ended_at_text_end,
   output logic        rsp_position_wrapped,
   output logic        empty,
   input  logic        pop
);

   logic       item_valid;
   logic       ev_valid;
   result_type ev_data;
   result_type head;
   logic       q_full;
   logic       q_empty;

   // Request accepted only while the queue has room for its result
   assign item_valid = push && !q_full;
   assign full       = q_full;
   assign empty      = q_empty;

   uscx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (req_text_byte),
      .item_last  (req_last_byte),
      .ev_valid   (ev_valid),
      .ev_data    (ev_data)
   );

   uscx_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (ev_valid),
      .wr_data  (ev_data),
      .rd_en    (pop),
      .rd_data  (head),
      .is_full  (q_full),
      .is_empty (q_empty)
   );

   // Result fields from the head of the queue
   assign rsp_url_start         = head.url_start;
   assign rsp_url_end           = head.url_end;
   assign rsp_ended_at_text_end = head.ended_at_text_end;
   assign rsp_position_wrapped  = head.position_wrapped;

endmodule
